// ===== rtl/cmc_pkg.sv =====
// Shared constants, types and codes of the column majority consensus unit.
`timescale 1ns / 1ps

package cmc_pkg;

	// Lanes carried by one column request, and rows that take part in the vote.
	localparam int Lanes     = 8;
	localparam int Rows      = 8;
	localparam int VoteLanes = (Rows < Lanes) ? Rows : Lanes;

	localparam int CodeW  = 3;
	localparam int CountW = $clog2(Lanes + 1);
	localparam int NumVotingCodes = 6;

	localparam int SymsW   = Lanes * CodeW;
	localparam int InDataW = SymsW + Lanes;
	localparam int OutBits = 2 * CodeW + CountW;
	localparam int OutDataW = ((OutBits + 7) / 8) * 8;

	// Symbol codes. Codes 6 and 7 are both no-calls.
	localparam logic [CodeW-1:0] CodeGap    = 3'd0;
	localparam logic [CodeW-1:0] CodeNoCall = 3'd6;

	// Status reported for each column.
	typedef enum logic [2:0] {
		StatusLeadSkip  = 3'd0,
		StatusAppend    = 3'd1,
		StatusGapOnly   = 3'd2,
		StatusStopHere  = 3'd3,
		StatusAfterStop = 3'd4
	} status_t;

	typedef struct packed {
		logic [CodeW-1:0]  code;
		logic [CountW-1:0] count;
	} vote_t;

endpackage

// ===== rtl/cmc_vote.sv =====
// Majority vote over the lanes of one column, ties going to the lowest code.
`timescale 1ns / 1ps

module cmc_vote (
	input  logic [cmc_pkg::SymsW-1:0] syms,
	input  logic [cmc_pkg::Lanes-1:0] valid,
	output cmc_pkg::vote_t            vote
);
	import cmc_pkg::*;

	logic [CountW-1:0] counts [NumVotingCodes];

	// One counter per voting code; no-call codes never match.
	always_comb begin
		for (int c = 0; c < NumVotingCodes; c++) begin
			counts[c] = '0;
			for (int k = 0; k < VoteLanes; k++) begin
				if (valid[k] && (syms[k*CodeW +: CodeW] == CodeW'(c))) begin
					counts[c] = counts[c] + CountW'(1);
				end
			end
		end
	end

	// Strictly greater replaces, so the lowest code keeps a tie.
	always_comb begin
		vote.code  = CodeNoCall;
		vote.count = '0;
		for (int c = 0; c < NumVotingCodes; c++) begin
			if (counts[c] > vote.count) begin
				vote.count = counts[c];
				vote.code  = CodeW'(c);
			end
		end
	end

endmodule

// ===== rtl/column_majority_consensus_unit.sv =====
// Top level of the column majority consensus unit: input stage, vote, status and output stage.
`timescale 1ns / 1ps
// Usage:
// Alignment columns arrive on the s_ channel, one column per request. s_tdata carries the
// eight 3-bit row symbols in bits 23:0 and the row valid bits in bits 31:24; s_tlast marks
// the final column of an alignment. Each column produces exactly one result request on the
// m_ channel: the winning code, its vote count and the column status, with m_tlast copying
// the column's last marker.
// A result shows on m_tvalid once its column has passed both registers: the column is registered
// at the accepting edge and its result when the pipeline advances. One column can be accepted
// every cycle while the receiver keeps m_tready high: the column register and the result
// register form a two-stage pipeline with the combinational vote between them.
// The started and stopped flags are updated as a column moves from the column register into
// the result register, so columns are judged strictly in arrival order; the flags clear
// after a column marked last.
// When the receiver holds m_tready low, the result stays in its register and the column
// register keeps taking a request until it is also full; then s_tready drops.
// Reset (arst_n low, asynchronous) empties both stages and clears both flags.
module column_majority_consensus_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [cmc_pkg::InDataW-1:0]  s_tdata,  // column_symbols [23:0], row_valid [31:24]
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [cmc_pkg::OutDataW-1:0] m_tdata,  // padded_code [2:0], winner_count [6:3],
	                                               // column_status [9:7], zero [15:10]
	output logic                         m_tlast
);
	import cmc_pkg::*;

	// Column register (stage 1).
	logic                valid_s1;
	logic [SymsW-1:0]    syms_s1;
	logic [Lanes-1:0]    rowv_s1;
	logic                last_s1;

	// Result register (stage 2).
	logic                valid_s2;
	vote_t               vote_s2;
	status_t             status_s2;
	logic                last_s2;

	// Consensus flags.
	logic                started_q;
	logic                stopped_q;

	logic                advance;
	logic                load_s1;
	logic                move_s2;
	vote_t               vote;
	status_t             status;
	logic                started_d;
	logic                stopped_d;

	// The whole pipeline advances when the result register is free or being drained.
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign load_s1  = s_tvalid && s_tready;
	assign move_s2  = valid_s1 && advance;

	cmc_vote u_vote (
		.syms  (syms_s1),
		.valid (rowv_s1),
		.vote  (vote)
	);

	// Status of the column in stage 1 and the flags it leaves behind.
	always_comb begin
		started_d = started_q;
		stopped_d = stopped_q;
		if (stopped_q) begin
			status = StatusAfterStop;
		end else if (vote.code == CodeNoCall) begin
			if (!started_q) begin
				status = StatusLeadSkip;
			end else begin
				status    = StatusStopHere;
				stopped_d = 1'b1;
			end
		end else if (vote.code != CodeGap) begin
			status    = StatusAppend;
			started_d = 1'b1;
		end else begin
			status = StatusGapOnly;
		end
		// The last column of an alignment leaves the flags clear for the next one.
		if (last_s1) begin
			started_d = 1'b0;
			stopped_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			started_q <= 1'b0;
			stopped_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (move_s2) begin
				started_q <= started_d;
				stopped_q <= stopped_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			syms_s1 <= s_tdata[SymsW-1:0];
			rowv_s1 <= s_tdata[SymsW +: Lanes];
			last_s1 <= s_tlast;
		end
		if (move_s2) begin
			vote_s2   <= vote;
			status_s2 <= status;
			last_s2   <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = last_s2;
	assign m_tdata  = OutDataW'({status_s2, vote_s2.count, vote_s2.code});

endmodule

// ===== rtl/cmc_checker.sv =====
// Port-level assertions for the column majority consensus unit, bound to the top level.
`timescale 1ns / 1ps

module cmc_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tready,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [cmc_pkg::OutDataW-1:0] m_tdata
);
	import cmc_pkg::*;

	logic [CodeW-1:0]  code;
	logic [CountW-1:0] count;
	logic [2:0]        status;

	assign code   = m_tdata[CodeW-1:0];
	assign count  = m_tdata[CodeW +: CountW];
	assign status = m_tdata[CodeW + CountW +: 3];

	// A stalled result must not vanish.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	// The input only stalls while a result is waiting on the receiver.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a waiting result");

	// A zero count and a no-call winner go together.
	a_nocall_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((count == '0) == (code == CodeNoCall)))
		else $error("winner count disagrees with no-call code");

	// A no-call column can only be skipped, stop the consensus or follow the stop.
	a_nocall_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (code == CodeNoCall) |->
			(status == StatusLeadSkip) || (status == StatusStopHere) ||
			(status == StatusAfterStop))
		else $error("no-call column with a base or gap status");

	// An appended base is never a gap or a no-call.
	a_append_base: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == StatusAppend) |->
			(code != CodeGap) && (code != CodeNoCall))
		else $error("appended column without a base");

endmodule

bind column_majority_consensus_unit cmc_checker u_cmc_checker (.*);

// ===== tb/tb_column_majority_consensus_unit.sv =====
// Self-checking testbench for the column majority consensus unit.
`timescale 1ns / 1ps

module tb_column_majority_consensus_unit;
	import cmc_pkg::*;

	// Symbol codes that the package does not name.
	localparam logic [CodeW-1:0] CodeA       = 3'd1;
	localparam logic [CodeW-1:0] CodeC       = 3'd2;
	localparam logic [CodeW-1:0] CodeG       = 3'd3;
	localparam logic [CodeW-1:0] CodeN       = 3'd4;
	localparam logic [CodeW-1:0] CodeT       = 3'd5;
	localparam logic [CodeW-1:0] CodeNoCall7 = 3'd7;

	localparam int ResetCycles   = 12;
	localparam int HoldOffCycles = 60;
	localparam int DrainCycles   = 10;
	localparam int CycleLimit    = 100000;
	localparam int MaxReports    = 10;

	// One result request as the block reports it.
	typedef struct packed {
		logic [CodeW-1:0]  code;
		logic [CountW-1:0] count;
		status_t           status;
		logic              last;
	} column_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata  = '0;
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tlast;

	// Consensus flags as the block should hold them after the columns accepted so far.
	logic alignment_started = 1'b0;
	logic alignment_stopped = 1'b0;

	column_result_t consensus_q[$];
	int unsigned    mismatch_count = 0;
	int unsigned    cycle_count    = 0;
	bit             idle_off       = 1'b0;
	bit             hold_req       = 1'b0;

	column_majority_consensus_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// Majority vote plus the started/stopped status rules for one column.
	function automatic column_result_t vote_column(input logic [SymsW-1:0] syms,
			input logic [Lanes-1:0] valid, input logic last);
		int unsigned    tally [NumVotingCodes];
		column_result_t res;
		logic [CodeW-1:0] code;
		int k;
		for (k = 0; k < NumVotingCodes; k++)
			tally[k] = 0;
		for (k = 0; k < VoteLanes; k++) begin
			code = syms[CodeW*k +: CodeW];
			if (valid[k] && code < NumVotingCodes)
				tally[code]++;
		end
		res.code  = CodeNoCall;
		res.count = '0;
		// Only a strictly larger tally displaces the winner, so ties keep the lower code.
		for (k = 0; k < NumVotingCodes; k++) begin
			if (tally[k] > res.count) begin
				res.count = CountW'(tally[k]);
				res.code  = CodeW'(k);
			end
		end
		if (alignment_stopped) begin
			res.status = StatusAfterStop;
		end else if (res.code == CodeNoCall) begin
			if (!alignment_started) begin
				res.status = StatusLeadSkip;
			end else begin
				res.status = StatusStopHere;
				alignment_stopped = 1'b1;
			end
		end else if (res.code != CodeGap) begin
			res.status = StatusAppend;
			alignment_started = 1'b1;
		end else begin
			res.status = StatusGapOnly;
		end
		if (last) begin
			alignment_started = 1'b0;
			alignment_stopped = 1'b0;
		end
		res.last = last;
		return res;
	endfunction

	function automatic void note_failure(input string what, input column_result_t want,
			input column_result_t got);
		mismatch_count++;
		if (mismatch_count <= MaxReports)
			$display("%0t %s: expected code %0d count %0d status %0d last %0d,",
				$realtime, what, want.code, want.count, want.status, want.last,
				" got code %0d count %0d status %0d last %0d",
				got.code, got.count, got.status, got.last);
	endfunction

	// Called right after a rising edge; returns right after the edge that takes the request.
	task automatic send_column(input logic [SymsW-1:0] syms, input logic [Lanes-1:0] valid,
			input logic last);
		if (!idle_off && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {valid, syms};
		s_tlast  <= last;
		do @(negedge clk); while (!s_tready);
		consensus_q = {consensus_q, vote_column(syms, valid, last)};
		@(posedge clk);
	endtask

	// The first n rows carry code a, the rest code b.
	function automatic logic [SymsW-1:0] split_rows(input logic [CodeW-1:0] a,
			input logic [CodeW-1:0] b, input int n);
		logic [SymsW-1:0] syms;
		int k;
		for (k = 0; k < Lanes; k++)
			syms[CodeW*k +: CodeW] = (k < n) ? a : b;
		return syms;
	endfunction

	// Columns shaped like real alignment data: mostly agreeing bases, some gaps and no-calls.
	task automatic make_column(output logic [SymsW-1:0] syms, output logic [Lanes-1:0] valid);
		int unsigned kind;
		int unsigned pick;
		logic [CodeW-1:0] base;
		int k;
		kind  = $urandom_range(99);
		base  = (kind < 65) ? CodeW'($urandom_range(1, 5)) : CodeGap;
		valid = ($urandom_range(99) < 50) ? '1 : Lanes'($urandom);
		for (k = 0; k < Lanes; k++) begin
			pick = $urandom_range(99);
			if (kind >= 85)
				syms[CodeW*k +: CodeW] = CodeW'($urandom);
			else if (kind >= 80)
				syms[CodeW*k +: CodeW] = CodeW'($urandom_range(6, 7));
			else if (pick < 70)
				syms[CodeW*k +: CodeW] = base;
			else if (pick < 80)
				syms[CodeW*k +: CodeW] = CodeGap;
			else if (pick < 90)
				syms[CodeW*k +: CodeW] = CodeW'($urandom_range(1, 5));
			else
				syms[CodeW*k +: CodeW] = CodeW'($urandom_range(6, 7));
		end
		if (kind >= 80 && kind < 85 && pick < 30)
			valid = '0;
	endtask

	// Vote extremes, tie breaking, last row, and every status transition.
	task automatic test_directed_columns();
		send_column({Lanes{CodeNoCall}}, '1, 1'b0);             // leading no-call
		send_column({Lanes{CodeNoCall7}}, '1, 1'b0);            // code 7 is a no-call too
		send_column({Lanes{CodeT}}, '0, 1'b0);                  // no row takes part
		send_column({Lanes{CodeGap}}, '1, 1'b0);                // gap does not start
		send_column(split_rows(CodeGap, CodeA, 4), '1, 1'b0);   // tie goes to the gap
		send_column({Lanes{CodeNoCall}}, '1, 1'b0);             // still a leading skip
		send_column(split_rows(CodeC, CodeA, 4), '1, 1'b0);     // tie goes to A, starts
		send_column({Lanes{CodeT}}, '1, 1'b0);                  // full vote
		send_column({Lanes{CodeG}}, 8'h80, 1'b0);               // only the last row votes
		send_column(split_rows(CodeN, CodeT, 3), '1, 1'b0);
		send_column(split_rows(CodeNoCall7, CodeC, 7), '1, 1'b0); // one vote among no-calls
		send_column({Lanes{CodeGap}}, '1, 1'b0);                // gap after a base
		send_column('0, '0, 1'b0);                              // no-call stops the consensus
		send_column({Lanes{CodeA}}, '1, 1'b0);                  // after the stop
		send_column({Lanes{CodeNoCall}}, '1, 1'b0);
		send_column(split_rows(CodeT, CodeG, 5), 8'h5A, 1'b1);  // last clears the flags
		send_column({Lanes{CodeGap}}, '1, 1'b0);
		send_column('1, '1, 1'b0);
		send_column({Lanes{CodeA}}, '1, 1'b1);                  // base on the last column
		send_column('1, '0, 1'b0);
		send_column({Lanes{CodeC}}, '1, 1'b0);
		send_column({Lanes{CodeNoCall}}, '1, 1'b1);             // stop on the last column
		send_column({Lanes{CodeNoCall}}, '1, 1'b0);
		send_column({Lanes{CodeN}}, '1, 1'b1);
	endtask

	// Whole alignments of random length, with a share of unstructured columns.
	task automatic test_random_alignments(input int n_items);
		logic [SymsW-1:0] syms;
		logic [Lanes-1:0] valid;
		int sent;
		int len;
		int col;
		bit noise;
		sent = 0;
		while (sent < n_items) begin
			len   = $urandom_range(1, 40);
			noise = ($urandom_range(99) < 10);
			for (col = 0; col < len; col++) begin
				if (noise) begin
					send_column(SymsW'($urandom), Lanes'($urandom), 1'($urandom));
				end else begin
					make_column(syms, valid);
					send_column(syms, valid, col == len - 1);
				end
				sent++;
			end
		end
	endtask

	// Neither side idles, so a column moves on every cycle.
	task automatic test_full_rate();
		idle_off = 1'b1;
		test_random_alignments(200);
		idle_off = 1'b0;
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering columns.
	task automatic test_backpressure();
		idle_off = 1'b1;
		hold_req = 1'b1;
		test_random_alignments(40);
		idle_off = 1'b0;
	endtask

	initial begin : receiver
		int held;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				for (held = 1; held < HoldOffCycles; held++)
					@(posedge clk);
			end else begin
				m_tready <= idle_off || ($urandom_range(99) >= 8);
			end
		end
	end

	// Outputs and m_tready are steady at the falling edge; a request seen here is taken
	// at the next rising edge.
	always @(negedge clk) begin
		column_result_t got;
		column_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.code   = m_tdata[CodeW-1:0];
			got.count  = m_tdata[CodeW +: CountW];
			got.status = status_t'(m_tdata[CodeW+CountW +: 3]);
			got.last   = m_tlast;
			if (consensus_q.size() == 0) begin
				want = '0;
				note_failure("unexpected result", want, got);
			end else begin
				want = consensus_q.pop_front();
				if (got !== want)
					note_failure("result mismatch", want, got);
			end
		end
	end

	initial begin
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_columns();
		test_full_rate();
		test_backpressure();
		test_random_alignments(1240);
		s_tvalid <= 1'b0;
		while (consensus_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cmc_pkg.sv
rtl/cmc_vote.sv
rtl/column_majority_consensus_unit.sv
rtl/cmc_checker.sv
tb/tb_column_majority_consensus_unit.sv
